@@ rtl/fssd_pkg.sv @@
package fssd_pkg;

  // flow phase
  typedef enum logic [1:0] {
    PH_INIT    = 2'd0,
    PH_HELLO   = 2'd1,
    PH_MESSAGE = 2'd2,
    PH_SERVICE = 2'd3
  } phase_t;

  // verdict codes
  localparam logic [1:0] VERDICT_INPROCESS = 2'd0;
  localparam logic [1:0] VERDICT_NOMATCH   = 2'd1;
  localparam logic [1:0] VERDICT_DETECTED  = 2'd2;
  localparam logic [1:0] VERDICT_RESERVED  = 2'd3;

  // configuration register indexes
  localparam logic CFG_PORT_THRESHOLD   = 1'b0;
  localparam logic CFG_INSPECTION_LIMIT = 1'b1;

  localparam logic [15:0] PORT_THRESHOLD_RST   = 16'd27000;
  localparam logic [7:0]  INSPECTION_LIMIT_RST = 8'd10;
  localparam logic [7:0]  COUNT_MAX            = 8'hff;

  // length tests
  localparam logic [15:0] LEN_START_MIN = 16'd4;   // at or above
  localparam logic [15:0] LEN_HELLO     = 16'd18;  // exact
  localparam logic [15:0] LEN_MSG_OVER  = 16'd8;   // strictly above
  localparam logic [15:0] LEN_QUERY     = 16'd7;   // exact
  localparam logic [15:0] LEN_RESP_OVER = 16'd10;  // strictly above

  // header signatures
  localparam logic [15:0]  MSG_MAGIC  = 16'hfefd;
  localparam logic [103:0] SIG_HELLO  = 104'h626174746c656669656c643200;
  localparam logic [55:0]  SIG_QUERY  = 56'hfefd0900000000;
  localparam logic [79:0]  SIG_RESP_A = 80'h11200001000050b91011;
  localparam logic [79:0]  SIG_RESP_B = 80'h11200001000030b91011;
  localparam logic [79:0]  SIG_RESP_C = 80'h112000010000a0980011;

  // queue
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // classified packet, front to back
  typedef struct packed {
    logic        flow_start;
    logic        len_zero;
    logic        responder;
    logic        start_hit;   // message header start path
    logic        hello_hit;   // hello signature
    logic        long_msg;    // length above eight
    logic        magic_hit;   // bytes 0..1 are the message magic
    logic        sig_hit;     // query or response signature
    logic [15:0] lead_word;   // bytes 0..1
    logic [15:0] msg_id;      // bytes 2..3
  } item_class_t;

endpackage

@@ rtl/fssd_front.sv @@
module fssd_front
  import fssd_pkg::*;
(
  input  logic        flow_start,
  input  logic [15:0] packet_length,
  input  logic [15:0] src_port,
  input  logic [15:0] dst_port,
  input  logic        from_responder,
  input  logic [63:0] head_bytes_0_7,
  input  logic [63:0] head_bytes_8_15,
  input  logic [15:0] head_bytes_16_17,
  input  logic [15:0] port_threshold,
  output item_class_t cls
);

  logic         port_ok;
  logic         magic;
  logic [103:0] hello_bytes;
  logic [79:0]  resp_bytes;
  logic         query_hit;
  logic         resp_hit;

  assign port_ok     = (src_port >= port_threshold) || (dst_port >= port_threshold);
  assign magic       = (head_bytes_0_7[63:48] == MSG_MAGIC);
  assign hello_bytes = {head_bytes_0_7[23:0], head_bytes_8_15, head_bytes_16_17};
  assign resp_bytes  = {head_bytes_0_7, head_bytes_8_15[63:48]};

  assign query_hit = (packet_length == LEN_QUERY) && (head_bytes_0_7[63:8] == SIG_QUERY);
  assign resp_hit  = (packet_length > LEN_RESP_OVER) &&
                     ((resp_bytes == SIG_RESP_A) || (resp_bytes == SIG_RESP_B) ||
                      (resp_bytes == SIG_RESP_C));

  always_comb begin
    cls.flow_start = flow_start;
    cls.len_zero   = (packet_length == '0);
    cls.responder  = from_responder;
    cls.start_hit  = port_ok && (packet_length >= LEN_START_MIN) && magic;
    cls.hello_hit  = (packet_length == LEN_HELLO) && (hello_bytes == SIG_HELLO);
    cls.long_msg   = (packet_length > LEN_MSG_OVER);
    cls.magic_hit  = magic;
    cls.sig_hit    = query_hit || resp_hit;
    cls.lead_word  = head_bytes_0_7[63:48];
    cls.msg_id     = head_bytes_0_7[47:32];
  end

endmodule

@@ rtl/fssd_queue.sv @@
module fssd_queue
  import fssd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  item_class_t push_item,
  output logic        not_full,
  input  logic        pop,
  output logic        not_empty,
  output item_class_t head_item
);

  item_class_t             entry_r [QDEPTH];
  logic [QPTR_W-1:0]       wptr_r, wptr_nxt;
  logic [QPTR_W-1:0]       rptr_r, rptr_nxt;
  logic [QCNT_W-1:0]       count_r, count_nxt;

  assign not_full  = (count_r != QCNT_W'(QDEPTH));
  assign not_empty = (count_r != '0);
  assign head_item = entry_r[rptr_r];

  always_comb begin
    wptr_nxt  = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt  = pop  ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wptr_r] <= push_item;
    end
  end

endmodule

@@ rtl/fssd_back.sv @@
module fssd_back
  import fssd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  inspection_limit,
  input  logic        item_valid,
  input  item_class_t item,
  output logic        item_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_verdict
);

  phase_t      phase_r, phase_nxt, phase_eff;
  logic [15:0] msg_id_r, msg_id_nxt, msg_id_eff;
  logic [7:0]  count_r, count_nxt, count_eff, count_inc;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  verdict_r, verdict_nxt;
  logic [1:0]  count_verdict;
  logic        echo_hit;

  assign item_pop = item_valid && (!out_valid_r || out_ready);

  // state as seen after an optional flow clear
  assign phase_eff  = item.flow_start ? PH_INIT : phase_r;
  assign msg_id_eff = item.flow_start ? '0 : msg_id_r;
  assign count_eff  = item.flow_start ? '0 : count_r;
  assign count_inc  = (count_eff == COUNT_MAX) ? count_eff : count_eff + 8'd1;
  assign count_verdict = (count_inc >= inspection_limit) ? VERDICT_NOMATCH : VERDICT_INPROCESS;
  assign echo_hit   = item.long_msg && (item.lead_word == msg_id_eff);

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    msg_id_nxt = msg_id_r;
    count_nxt  = count_r;
    if (item_pop) begin
      phase_nxt  = phase_eff;
      msg_id_nxt = msg_id_eff;
      count_nxt  = count_eff;
      if (!item.len_zero) begin
        case (phase_eff)
          PH_INIT: begin
            if (item.start_hit) begin
              phase_nxt  = PH_MESSAGE;
              msg_id_nxt = item.msg_id;
              count_nxt  = count_inc;
            end else if (item.hello_hit) begin
              phase_nxt = PH_HELLO;
              count_nxt = count_inc;
            end
          end
          PH_MESSAGE: begin
            if (echo_hit) begin
              if (!item.responder) begin
                phase_nxt = PH_SERVICE;
                count_nxt = count_inc;
              end
            end else if (item.long_msg && item.magic_hit) begin
              msg_id_nxt = item.msg_id;
              count_nxt  = count_inc;
            end else begin
              phase_nxt = PH_INIT;
              count_nxt = count_inc;
            end
          end
          PH_HELLO: begin
            if (item.sig_hit && !item.responder) begin
              phase_nxt = PH_SERVICE;
              count_nxt = count_inc;
            end
          end
          PH_SERVICE: begin
            if (!item.responder) begin
              count_nxt = count_inc;
            end
          end
          default: begin
            phase_nxt = PH_INIT;
          end
        endcase
      end
    end
  end

  // verdict
  always_comb begin
    verdict_nxt = VERDICT_NOMATCH;
    if (item.len_zero) begin
      verdict_nxt = VERDICT_INPROCESS;
    end else begin
      case (phase_eff)
        PH_INIT: begin
          if (item.start_hit || item.hello_hit) begin
            verdict_nxt = count_verdict;
          end
        end
        PH_MESSAGE: begin
          if (echo_hit && item.responder) begin
            verdict_nxt = VERDICT_DETECTED;
          end else begin
            verdict_nxt = count_verdict;
          end
        end
        PH_HELLO: begin
          if (item.sig_hit) begin
            verdict_nxt = item.responder ? VERDICT_DETECTED : count_verdict;
          end
        end
        PH_SERVICE: begin
          verdict_nxt = item.responder ? VERDICT_DETECTED : count_verdict;
        end
        default: begin
          verdict_nxt = VERDICT_NOMATCH;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (item_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_INIT;
      msg_id_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      msg_id_r    <= msg_id_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      verdict_r <= verdict_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = verdict_r;

endmodule

@@ rtl/flow_service_signature_detector.sv @@
// Per-flow service classifier: takes one packet summary per cycle while in_ready is high
// and returns one verdict (0 in process, 1 no match, 2 detected) per packet, in order.
// Throughput is one transaction per clock on both sides while out_ready stays high. Each
// accepted packet is registered in the four-entry classification queue and then in the
// verdict register before out_valid rises. The back end updates the single flow state
// once per popped packet. While the output is stalled, up to four more packets are taken
// before in_ready drops. Configuration registers (index 0 port threshold,
// index 1 inspection limit) are written through cfg_we, cfg_index and cfg_wdata; the
// user must write them only while no transaction is in flight, which the block does
// not enforce.
module flow_service_signature_detector
  import fssd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  // packet summaries
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_flow_start,
  input  logic [15:0] in_packet_length,
  input  logic [15:0] in_src_port,
  input  logic [15:0] in_dst_port,
  input  logic        in_from_responder,
  input  logic [63:0] in_head_bytes_0_7,
  input  logic [63:0] in_head_bytes_8_15,
  input  logic [15:0] in_head_bytes_16_17,
  // verdicts
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_verdict
);

  logic [15:0] port_threshold_r, port_threshold_nxt;
  logic [7:0]  inspection_limit_r, inspection_limit_nxt;

  item_class_t front_cls;
  item_class_t head_cls;
  logic        q_push;
  logic        q_not_full;
  logic        q_not_empty;
  logic        q_pop;

  // configuration registers; the user must write them only while idle, the block does not enforce it
  always_comb begin
    port_threshold_nxt   = port_threshold_r;
    inspection_limit_nxt = inspection_limit_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_PORT_THRESHOLD:   port_threshold_nxt   = cfg_wdata;
        CFG_INSPECTION_LIMIT: inspection_limit_nxt = cfg_wdata[7:0];
        default: begin
          port_threshold_nxt = port_threshold_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_threshold_r   <= PORT_THRESHOLD_RST;
      inspection_limit_r <= INSPECTION_LIMIT_RST;
    end else begin
      port_threshold_r   <= port_threshold_nxt;
      inspection_limit_r <= inspection_limit_nxt;
    end
  end

  // front end: stateless header compares, one packet per cycle
  fssd_front u_front (
    .flow_start       (in_flow_start),
    .packet_length    (in_packet_length),
    .src_port         (in_src_port),
    .dst_port         (in_dst_port),
    .from_responder   (in_from_responder),
    .head_bytes_0_7   (in_head_bytes_0_7),
    .head_bytes_8_15  (in_head_bytes_8_15),
    .head_bytes_16_17 (in_head_bytes_16_17),
    .port_threshold   (port_threshold_r),
    .cls              (front_cls)
  );

  // input is taken whenever the queue has room
  assign in_ready = q_not_full;
  assign q_push   = in_valid && q_not_full;

  // classification queue decouples the front from the flow state
  fssd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (front_cls),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_item (head_cls)
  );

  // back end: flow phase, message id, inspection count and verdict register
  fssd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .inspection_limit (inspection_limit_r),
    .item_valid       (q_not_empty),
    .item             (head_cls),
    .item_pop         (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_verdict      (out_verdict)
  );

`ifndef ASSERT_OFF
  // nothing pending and room for input straight after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  // every entry taken from the queue shows up as a verdict
  a_pop_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid)
    else $error("queue entry popped without a verdict");

  // the reserved verdict code is never produced
  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_verdict != VERDICT_RESERVED)
    else $error("reserved verdict code on output");

  // a pop only happens when the verdict slot is free or being drained
  a_pop_slot: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_not_empty && (!out_valid || out_ready))
    else $error("verdict overwritten before transaction completed");
`endif

endmodule

@@ tb/tb_flow_service_signature_detector.sv @@
`timescale 1ns / 100ps

module tb_flow_service_signature_detector
  import fssd_pkg::*;
();

  // header signatures, kept apart from the package so the check does not share its constants
  localparam logic [15:0]  HDR_MAGIC   = 16'hfefd;
  localparam logic [103:0] HELLO_SIG   = 104'h626174746c656669656c643200;
  localparam logic [55:0]  QUERY_SIG   = 56'hfefd0900000000;
  localparam logic [79:0]  RESP_SIG_A  = 80'h11200001000050b91011;
  localparam logic [79:0]  RESP_SIG_B  = 80'h11200001000030b91011;
  localparam logic [79:0]  RESP_SIG_C  = 80'h112000010000a0980011;
  localparam int           STALL_LIMIT = 2000;

  // one packet summary, the 18 head bytes as one vector with byte 0 on top
  typedef struct {
    logic         flow_start;
    logic [15:0]  len;
    logic [15:0]  sp;
    logic [15:0]  dp;
    logic         resp;
    logic [143:0] head;
  } pkt_summary_t;

  typedef struct {
    pkt_summary_t pkt;
    bit           typed;
    logic [1:0]   verdict;
  } directed_row_t;

  logic        clk;
  logic        rst_n               = 1'b0;
  logic        cfg_we              = 1'b0;
  logic        cfg_index           = CFG_PORT_THRESHOLD;
  logic [15:0] cfg_wdata           = '0;
  logic        in_valid            = 1'b0;
  logic        in_ready;
  logic        in_flow_start       = 1'b0;
  logic [15:0] in_packet_length    = '0;
  logic [15:0] in_src_port         = '0;
  logic [15:0] in_dst_port         = '0;
  logic        in_from_responder   = 1'b0;
  logic [63:0] in_head_bytes_0_7   = '0;
  logic [63:0] in_head_bytes_8_15  = '0;
  logic [15:0] in_head_bytes_16_17 = '0;
  logic        out_valid;
  logic        out_ready           = 1'b0;
  logic [1:0]  out_verdict;

  // predicted flow state and register copies
  phase_t      flow_phase    = PH_INIT;
  logic [15:0] last_msg_id   = '0;
  logic [7:0]  inspected_cnt = '0;
  logic [15:0] port_thr      = 16'd27000;
  logic [7:0]  insp_limit    = 8'd10;

  logic [1:0]      verdict_q[$];    // verdicts still owed by the block
  directed_row_t   directed_rows[$];
  bit              typed_pending = 1'b0;
  logic [1:0]      typed_verdict = '0;
  int              error_cnt     = 0;
  int              stall_cnt     = 0;
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;

  flow_service_signature_detector DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_flow_start       (in_flow_start),
    .in_packet_length    (in_packet_length),
    .in_src_port         (in_src_port),
    .in_dst_port         (in_dst_port),
    .in_from_responder   (in_from_responder),
    .in_head_bytes_0_7   (in_head_bytes_0_7),
    .in_head_bytes_8_15  (in_head_bytes_8_15),
    .in_head_bytes_16_17 (in_head_bytes_16_17),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_verdict         (out_verdict)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // verdict prediction
  // ---------------------------------------------------------------------------

  // one more in-process packet; the count sticks at its top
  function automatic logic [1:0] bump_inspected();
    if (inspected_cnt != 8'hff) inspected_cnt = inspected_cnt + 8'd1;
    return (inspected_cnt >= insp_limit) ? VERDICT_NOMATCH : VERDICT_INPROCESS;
  endfunction

  // a match only counts as final on the responder side
  function automatic logic [1:0] service_seen(logic resp);
    if (!resp) begin
      flow_phase = PH_SERVICE;
      return bump_inspected();
    end
    return VERDICT_DETECTED;
  endfunction

  function automatic logic [1:0] classify_packet(pkt_summary_t p);
    logic [15:0] lead;
    logic [15:0] msg_id;
    logic [1:0]  v;
    lead   = p.head[143:128];
    msg_id = p.head[127:112];
    if (p.flow_start) begin
      flow_phase    = PH_INIT;
      last_msg_id   = '0;
      inspected_cnt = '0;
    end
    // an empty packet changes nothing
    if (p.len == 16'd0) return VERDICT_INPROCESS;
    case (flow_phase)
      PH_INIT: begin
        if ((p.sp >= port_thr || p.dp >= port_thr) && p.len >= 16'd4 && lead == HDR_MAGIC) begin
          last_msg_id = msg_id;
          flow_phase  = PH_MESSAGE;
          v           = bump_inspected();
        end else if (p.len == 16'd18 && p.head[103:0] == HELLO_SIG) begin
          flow_phase = PH_HELLO;
          v          = bump_inspected();
        end else begin
          v = VERDICT_NOMATCH;
        end
      end
      PH_MESSAGE: begin
        // an echo of the id wins over a fresh header
        if (p.len > 16'd8 && lead == last_msg_id) begin
          v = service_seen(p.resp);
        end else if (p.len > 16'd8 && lead == HDR_MAGIC) begin
          last_msg_id = msg_id;
          v           = bump_inspected();
        end else begin
          flow_phase = PH_INIT;
          v          = bump_inspected();
        end
      end
      PH_HELLO: begin
        if ((p.len == 16'd7 && p.head[143:88] == QUERY_SIG) ||
            (p.len > 16'd10 && (p.head[143:64] == RESP_SIG_A ||
                                p.head[143:64] == RESP_SIG_B ||
                                p.head[143:64] == RESP_SIG_C)))
          v = service_seen(p.resp);
        else
          v = VERDICT_NOMATCH;
      end
      default: v = service_seen(p.resp);
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic pkt_summary_t summary(logic fs, logic [15:0] len, logic [15:0] sp,
                                           logic [15:0] dp, logic resp, logic [143:0] head);
    pkt_summary_t p;
    p.flow_start = fs;
    p.len        = len;
    p.sp         = sp;
    p.dp         = dp;
    p.resp       = resp;
    p.head       = head;
    return p;
  endfunction

  function automatic logic [143:0] rand_head();
    logic [159:0] r;
    r = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    return r[143:0];
  endfunction

  // lengths cluster around the compare boundaries, with the full range mixed in
  function automatic logic [15:0] rand_len();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom_range(1, 20));
      1:       return 16'hffff;
      2, 3:    return 16'($urandom_range(1, 80));
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic logic [15:0] rand_port();
    case ($urandom_range(0, 7))
      0:       return port_thr;
      1:       return port_thr - 16'd1;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] above_thr();
    return port_thr + 16'($urandom_range(0, 65535 - port_thr));
  endfunction

  // mostly well-formed follow-ups for the phase the flow is in, the rest noise
  function automatic pkt_summary_t next_packet();
    pkt_summary_t p;
    phase_t       ph;
    int           pick;
    p = summary($urandom_range(0, 11) == 0, rand_len(), rand_port(), rand_port(),
                1'($urandom_range(0, 1)), rand_head());
    if ($urandom_range(0, 24) == 0) begin
      p.len = '0;
      return p;
    end
    ph   = p.flow_start ? PH_INIT : flow_phase;
    pick = $urandom_range(0, 9);
    case (ph)
      PH_INIT: begin
        if (pick < 4) begin
          p.head[143:128] = HDR_MAGIC;
          p.len = (pick == 0) ? 16'd4 : 16'($urandom_range(4, 64));
          // pick 1 leaves the ports to chance
          if (pick != 1) begin
            if (pick[0]) p.sp = above_thr();
            else p.dp = above_thr();
          end
        end else if (pick < 7) begin
          p.head[103:0] = HELLO_SIG;
          p.len = 16'd18;
          if (pick == 6) begin
            // near miss: one bit off, or one byte too short or long
            if ($urandom_range(0, 1)) p.head ^= 144'd1 << $urandom_range(0, 103);
            else p.len = $urandom_range(0, 1) ? 16'd17 : 16'd19;
          end
        end
      end
      PH_MESSAGE: begin
        p.len = 16'($urandom_range(9, 80));
        if (pick < 5) begin
          p.head[143:128] = last_msg_id;
        end else if (pick < 7) begin
          p.head[143:128] = HDR_MAGIC;
        end else if (pick == 7) begin
          p.head[143:128] = last_msg_id;
          p.len = 16'd8;
        end else begin
          p.len = rand_len();
        end
      end
      PH_HELLO: begin
        case (pick)
          0, 1: begin
            p.head[143:88] = QUERY_SIG;
            p.len = 16'd7;
          end
          2, 3, 4: begin
            p.head[143:64] = (pick == 2) ? RESP_SIG_A : (pick == 3) ? RESP_SIG_B : RESP_SIG_C;
            p.len = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom_range(11, 40));
          end
          5: begin
            p.head[143:64] = RESP_SIG_A;
            p.len = 16'd10;
          end
          6: begin
            p.head[143:88] = QUERY_SIG;
            if ($urandom_range(0, 1)) p.len = 16'd8;
            else begin
              p.len = 16'd7;
              p.head ^= 144'd1 << $urandom_range(88, 143);
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic drive_packet(input pkt_summary_t p, input bit typed, input logic [1:0] verdict);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    typed_pending        = typed;
    typed_verdict        = verdict;
    in_valid            <= 1'b1;
    in_flow_start       <= p.flow_start;
    in_packet_length    <= p.len;
    in_src_port         <= p.sp;
    in_dst_port         <= p.dp;
    in_from_responder   <= p.resp;
    in_head_bytes_0_7   <= p.head[143:80];
    in_head_bytes_8_15  <= p.head[79:16];
    in_head_bytes_16_17 <= p.head[15:0];
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic add_row(input pkt_summary_t p, input bit typed, input logic [1:0] verdict);
    directed_row_t r;
    r.pkt     = p;
    r.typed   = typed;
    r.verdict = verdict;
    directed_rows.push_back(r);
  endtask

  // let every owed verdict come back before touching the registers
  task automatic settle();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // both registers on back-to-back cycles, write enable held across them
  task automatic write_settings(input logic [15:0] thr, input logic [7:0] limit);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PORT_THRESHOLD;
    cfg_wdata <= thr;
    port_thr   = thr;
    @(negedge clk);
    cfg_index <= CFG_INSPECTION_LIMIT;
    cfg_wdata <= {8'h00, limit};
    insp_limit = limit;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) drive_packet(next_packet(), 1'b0, '0);
  endtask

  // one flow held open long enough to drive the count to its top, where it sticks
  task automatic run_long_flow(input int n);
    pkt_summary_t p;
    drive_packet(summary(1'b1, 16'd4, 16'd0, 16'hffff, 1'b0, {HDR_MAGIC, 16'h0a5c, 112'h0}),
                 1'b0, '0);
    drive_packet(summary(1'b0, 16'd9, 16'd0, 16'd0, 1'b0, {16'h0a5c, 128'h0}), 1'b0, '0);
    for (int i = 0; i < n; i++) begin
      p = summary(1'b0, 16'($urandom_range(1, 65535)), rand_port(), rand_port(), 1'b0,
                  rand_head());
      // the last few come from the responder and should detect
      p.resp = (i >= n - 6);
      drive_packet(p, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver back-pressure
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // checking and watchdog, both sampled at the rising edge
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : verdict_check
    pkt_summary_t seen;
    logic [1:0]   want;
    logic [1:0]   predicted;
    if (rst_n) begin
      // results first, so a verdict can never be matched against its own transaction
      if (out_valid === 1'b1 && out_ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected verdict, expected none, got %0d", $time, out_verdict);
          error_cnt++;
        end else begin
          want = verdict_q.pop_front();
          if (out_verdict !== want) begin
            $display("%0t: verdict mismatch, expected %0d, got %0d", $time, want, out_verdict);
            error_cnt++;
          end
        end
      end
      if (in_valid && in_ready === 1'b1) begin
        seen.flow_start = in_flow_start;
        seen.len        = in_packet_length;
        seen.sp         = in_src_port;
        seen.dp         = in_dst_port;
        seen.resp       = in_from_responder;
        seen.head       = {in_head_bytes_0_7, in_head_bytes_8_15, in_head_bytes_16_17};
        predicted       = classify_packet(seen);
        verdict_q.push_back(typed_pending ? typed_verdict : predicted);
      end
    end
    // nothing moving on either side for too long means a hang
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
      stall_cnt = 0;
    else
      stall_cnt++;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL flow_service_signature_detector");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin
    // directed rows at the reset settings (threshold 27000, limit 10)
    add_row(summary(1'b1, 16'd0, 16'd0, 16'd0, 1'b0, '0), 1'b1, VERDICT_INPROCESS);
    add_row(summary(1'b0, 16'd1, 16'd0, 16'd0, 1'b0, '0), 1'b1, VERDICT_NOMATCH);
    add_row(summary(1'b1, 16'hffff, 16'hffff, 16'hffff, 1'b1, '1), 1'b1, VERDICT_NOMATCH);
    // message header start at the threshold, then its echo from each side
    add_row(summary(1'b1, 16'd4, 16'd27000, 16'd0, 1'b0, {HDR_MAGIC, 16'h1234, 112'h0}),
            1'b1, VERDICT_INPROCESS);
    add_row(summary(1'b0, 16'd9, 16'd0, 16'd0, 1'b1, {16'h1234, 128'h0}), 1'b1,
            VERDICT_DETECTED);
    add_row(summary(1'b0, 16'd9, 16'd0, 16'd0, 1'b0, {16'h1234, 128'h0}), 1'b0, '0);
    add_row(summary(1'b0, 16'd1, 16'd0, 16'd0, 1'b1, '0), 1'b1, VERDICT_DETECTED);
    // empty packet mid-flow
    add_row(summary(1'b0, 16'd0, 16'hffff, 16'hffff, 1'b1, '1), 1'b1, VERDICT_INPROCESS);
    // ports one below the threshold, and a header one byte too short
    add_row(summary(1'b1, 16'd4, 16'd26999, 16'd26999, 1'b0, {HDR_MAGIC, 128'h0}), 1'b1,
            VERDICT_NOMATCH);
    add_row(summary(1'b1, 16'd3, 16'd0, 16'd27000, 1'b0, {HDR_MAGIC, 128'h0}), 1'b1,
            VERDICT_NOMATCH);
    // hello, then query
    add_row(summary(1'b1, 16'd18, 16'd0, 16'd0, 1'b0, {40'h0, HELLO_SIG}), 1'b0, '0);
    add_row(summary(1'b0, 16'd7, 16'd0, 16'd0, 1'b1, {QUERY_SIG, 88'h0}), 1'b1,
            VERDICT_DETECTED);
    // hello, then each response signature
    add_row(summary(1'b1, 16'd18, 16'd0, 16'd0, 1'b0, {40'hffffffffff, HELLO_SIG}), 1'b0, '0);
    add_row(summary(1'b0, 16'd11, 16'd0, 16'd0, 1'b1, {RESP_SIG_A, 64'h0}), 1'b1,
            VERDICT_DETECTED);
    add_row(summary(1'b1, 16'd18, 16'd0, 16'd0, 1'b0, {40'h0, HELLO_SIG}), 1'b0, '0);
    add_row(summary(1'b0, 16'd10, 16'd0, 16'd0, 1'b1, {RESP_SIG_A, 64'h0}), 1'b1,
            VERDICT_NOMATCH);
    add_row(summary(1'b0, 16'd11, 16'd0, 16'd0, 1'b0, {RESP_SIG_B, 64'h0}), 1'b0, '0);
    add_row(summary(1'b0, 16'd1, 16'd0, 16'd0, 1'b1, '0), 1'b1, VERDICT_DETECTED);
    add_row(summary(1'b1, 16'd18, 16'd0, 16'd0, 1'b0, {40'h0, HELLO_SIG}), 1'b0, '0);
    add_row(summary(1'b0, 16'hffff, 16'd0, 16'd0, 1'b1, {RESP_SIG_C, 64'hffffffffffffffff}),
            1'b1, VERDICT_DETECTED);
    // message id equal to the magic itself: the echo test comes first
    add_row(summary(1'b1, 16'd4, 16'd0, 16'hffff, 1'b0, {HDR_MAGIC, HDR_MAGIC, 112'h0}),
            1'b0, '0);
    add_row(summary(1'b0, 16'd9, 16'd0, 16'd0, 1'b1, {HDR_MAGIC, 16'h0002, 112'h0}), 1'b1,
            VERDICT_DETECTED);
    // fresh header replaces the id, then a short echo drops back to init
    add_row(summary(1'b1, 16'd4, 16'hffff, 16'd0, 1'b0, {HDR_MAGIC, 16'h0001, 112'h0}),
            1'b0, '0);
    add_row(summary(1'b0, 16'd9, 16'd0, 16'd0, 1'b0, {HDR_MAGIC, 16'h0002, 112'h0}), 1'b0, '0);
    add_row(summary(1'b0, 16'd8, 16'd0, 16'd0, 1'b1, {16'h0002, 128'h0}), 1'b0, '0);
    add_row(summary(1'b0, 16'd9, 16'd0, 16'd0, 1'b1, {16'h0002, 128'h0}), 1'b0, '0);

    // synchronous reset, released at a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // sender idles lightly, receiver heavily
    send_idle_pct = 26;
    recv_idle_pct = 46;
    foreach (directed_rows[i])
      drive_packet(directed_rows[i].pkt, directed_rows[i].typed, directed_rows[i].verdict);
    settle();
    write_settings(16'h0000, 8'd255);
    run_random(150);

    // the other way round
    settle();
    send_idle_pct = 46;
    recv_idle_pct = 26;
    write_settings(16'hffff, 8'd1);
    run_random(150);
    settle();
    // zero limit: every in-process path answers no match
    write_settings(16'($urandom()), 8'd0);
    run_random(120);

    // full rate on both sides
    settle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_settings(16'($urandom()), 8'($urandom_range(1, 255)));
    run_random(120);
    settle();
    write_settings(16'd27000, 8'd255);
    run_long_flow(270);

    settle();
    repeat (10) @(posedge clk);
    if (verdict_q.size() != 0) begin
      $display("%0t: %0d verdicts never arrived, first expected %0d", $time, verdict_q.size(),
               verdict_q[0]);
      error_cnt++;
    end
    if (error_cnt == 0)
      $display("PASS flow_service_signature_detector");
    else
      $display("FAIL flow_service_signature_detector");
    $finish;
  end

endmodule
